>>> rtl/vcrd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcrd_pkg: shared types and constants of the vector clock race detector
// Holds event codes, race codes and the controller-to-datapath command set.
// ---------------------------------------------------------------------------
package vcrd_pkg;

    localparam int NumThreadsDef = 8;
    localparam int NumLocksDef   = 8;
    localparam int NumVarsDef    = 64;
    localparam int ClockBitsDef  = 32;

    localparam int OpW   = 3;
    localparam int TidW  = 3;
    localparam int VarW  = 6;
    localparam int LockW = 3;
    localparam int KindW = 2;

    // event kinds
    localparam logic [OpW-1:0] OP_READ    = 3'd0;
    localparam logic [OpW-1:0] OP_WRITE   = 3'd1;
    localparam logic [OpW-1:0] OP_ACQUIRE = 3'd2;
    localparam logic [OpW-1:0] OP_RELEASE = 3'd3;
    localparam logic [OpW-1:0] OP_FORK    = 3'd4;
    localparam logic [OpW-1:0] OP_JOIN    = 3'd5;

    // race kinds
    localparam logic [KindW-1:0] KIND_NONE = 2'd0;
    localparam logic [KindW-1:0] KIND_WR   = 2'd1;
    localparam logic [KindW-1:0] KIND_WW   = 2'd2;
    localparam logic [KindW-1:0] KIND_RW   = 2'd3;

    // datapath step commands
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,     // latch request, look up variable shadow
        CMD_CLR,      // clearing pass step
        CMD_CHK,      // clock reads, plus epoch checks for read or write
        CMD_WALK,     // one vector entry step
        CMD_FINISH    // commit and produce result
    } cmd_e_t;

    typedef struct packed {
        cmd_e_t cmd;
    } vcrd_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic walk_done;
        logic need_walk;
    } vcrd_sts_t;

endpackage : vcrd_pkg
`default_nettype wire

>>> rtl/vector_clock_race_detector_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vector_clock_race_detector_unit: vector clock data race detector
// Checks each memory or synchronization request against per-thread clocks.
// ---------------------------------------------------------------------------
// Sequence: load, check, an optional vector walk, then finish; a walk
//   (every valid sync request, read promotion, write after shared read)
//   reads each clock entry in one step and writes it in the next.
// One request at a time: the next request is accepted once the result is
//   registered; a finished result waits while the output register is full.
// Reset: synchronous; a clearing pass over max(NUM_THREADS^2, NUM_LOCKS*
//   NUM_THREADS, NUM_VARS) addresses runs after reset with s_ready low.
module vector_clock_race_detector_unit import vcrd_pkg::*; #(
    parameter int NUM_THREADS = NumThreadsDef,
    parameter int NUM_LOCKS   = NumLocksDef,
    parameter int NUM_VARS    = NumVarsDef,
    parameter int CLOCK_BITS  = ClockBitsDef
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [OpW-1:0]   s_op,
    input  wire logic [TidW-1:0]  s_thread,
    input  wire logic [VarW-1:0]  s_variable,
    input  wire logic [LockW-1:0] s_lock_id,
    input  wire logic [TidW-1:0]  s_peer_thread,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_race,
    output logic [KindW-1:0]      m_race_kind
);
    vcrd_cmd_t        cmd;
    vcrd_sts_t        sts;
    logic             cap;
    logic             res_race;
    logic [KindW-1:0] res_kind;
    logic             race_reg;
    logic [KindW-1:0] kind_reg;

    vcrd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd), .cap(cap));

    vcrd_datapath #(
        .NumThreads(NUM_THREADS), .NumLocks(NUM_LOCKS),
        .NumVars(NUM_VARS), .ClockBits(CLOCK_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .s_op(s_op), .s_thread(s_thread),
        .s_variable(s_variable), .s_lock_id(s_lock_id), .s_peer_thread(s_peer_thread),
        .sts(sts), .res_race(res_race), .res_kind(res_kind));

    // output register
    always_ff @(posedge aclk) begin
        if (cap) begin
            race_reg <= res_race;
            kind_reg <= res_kind;
        end
    end

    assign m_race      = race_reg;
    assign m_race_kind = kind_reg;
endmodule : vector_clock_race_detector_unit
`default_nettype wire

>>> rtl/vcrd_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcrd_ram: generic single-port RAM
// One access per cycle; read data is registered (old contents during a write).
// ---------------------------------------------------------------------------
module vcrd_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write or read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule : vcrd_ram
`default_nettype wire

>>> rtl/vcrd_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcrd_datapath: clock stores and race checks
// Holds thread/lock clocks and per-variable shadows, walks one vector entry
// per read-then-write step pair.
// ---------------------------------------------------------------------------
module vcrd_datapath import vcrd_pkg::*; #(
    parameter int NumThreads = NumThreadsDef,
    parameter int NumLocks   = NumLocksDef,
    parameter int NumVars    = NumVarsDef,
    parameter int ClockBits  = ClockBitsDef
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire vcrd_cmd_t        cmd,
    input  wire logic [OpW-1:0]   s_op,
    input  wire logic [TidW-1:0]  s_thread,
    input  wire logic [VarW-1:0]  s_variable,
    input  wire logic [LockW-1:0] s_lock_id,
    input  wire logic [TidW-1:0]  s_peer_thread,
    output vcrd_sts_t             sts,
    output logic                  res_race,
    output logic [KindW-1:0]      res_kind
);
    localparam int TW  = (NumThreads > 1) ? $clog2(NumThreads) : 1;
    localparam int VW  = (NumVars > 1) ? $clog2(NumVars) : 1;
    localparam int LW  = (NumLocks > 1) ? $clog2(NumLocks) : 1;
    localparam int TCD = NumThreads * NumThreads;
    localparam int LCD = NumLocks * NumThreads;
    localparam int RVD = NumVars * NumThreads;
    localparam int TCA = $clog2(TCD);
    localparam int LCA = (LCD > 1) ? $clog2(LCD) : 1;
    localparam int RVA = $clog2(RVD);
    localparam int SHW = 1 + ClockBits + TW + ClockBits + TW;
    localparam int CLRN = (TCD > LCD) ? ((TCD > NumVars) ? TCD : NumVars)
                                      : ((LCD > NumVars) ? LCD : NumVars);
    localparam int CW  = $clog2(CLRN + 1);
    localparam logic [ClockBits-1:0] ClkMax = '1;

    // latched request
    logic [OpW-1:0]  op_reg;
    logic [TW-1:0]   t_reg, u_reg;
    logic [VW-1:0]   x_reg;
    logic [LW-1:0]   m_reg;
    logic            valid_ev_reg;

    // variable shadow fields
    logic                 sh_vec_reg;
    logic [ClockBits-1:0] sh_rt_reg, sh_wt_reg;
    logic [TW-1:0]        sh_ru_reg, sh_wu_reg;
    logic [ClockBits-1:0] ct_reg;       // c[t]
    logic [ClockBits-1:0] cw_reg;       // c[write thread]
    logic [ClockBits-1:0] cr_reg;       // c[read thread]
    logic [ClockBits-1:0] cu_reg;       // peer's own entry (join bump)
    logic [KindW-1:0]     kind_reg;
    logic                 race_reg;
    logic                 need_walk_reg;
    logic [1:0]           phase_reg;
    logic [TW:0]          idx_reg;
    logic [CW-1:0]        clr_reg;

    // memories
    logic                 tc_we, lc_we, rv_we, sh_we;
    logic [TCA-1:0]       tc_addr;
    logic [LCA-1:0]       lc_addr;
    logic [RVA-1:0]       rv_addr;
    logic [VW-1:0]        sh_addr;
    logic [ClockBits-1:0] tc_wd, tc_rd, lc_wd, lc_rd, rv_wd, rv_rd;
    logic [SHW-1:0]       sh_wd, sh_rd;
    logic [TCA-1:0]       tc2_addr;
    logic [ClockBits-1:0] tc2_rd;

    vcrd_ram #(.Width(ClockBits), .Depth(TCD)) u_tc (
        .aclk(aclk), .we(tc_we), .addr(tc_addr), .wdata(tc_wd), .rdata(tc_rd));
    // second copy of thread clocks, written in lockstep, for a second read port
    vcrd_ram #(.Width(ClockBits), .Depth(TCD)) u_tc2 (
        .aclk(aclk), .we(tc_we), .addr(tc_we ? tc_addr : tc2_addr),
        .wdata(tc_wd), .rdata(tc2_rd));
    vcrd_ram #(.Width(ClockBits), .Depth(LCD)) u_lc (
        .aclk(aclk), .we(lc_we), .addr(lc_addr), .wdata(lc_wd), .rdata(lc_rd));
    vcrd_ram #(.Width(ClockBits), .Depth(RVD)) u_rv (
        .aclk(aclk), .we(rv_we), .addr(rv_addr), .wdata(rv_wd), .rdata(rv_rd));
    vcrd_ram #(.Width(SHW), .Depth(NumVars)) u_sh (
        .aclk(aclk), .we(sh_we), .addr(sh_addr), .wdata(sh_wd), .rdata(sh_rd));

    function automatic logic [TCA-1:0] tca(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TCA+TW-1:0] p;
        p = TCA'(a) * TCA'(NumThreads) + TCA'(b);
        return p[TCA-1:0];
    endfunction

    // walk index (the walk alternates read steps and write steps, starting with a read)
    logic [TW-1:0] i_cur;
    logic          i_is_t, i_is_ru;
    logic          step_wr;          // this cycle is the write half of a step
    logic          epw_ok, epr_ok;
    logic [ClockBits-1:0] jmax;

    assign i_cur   = idx_reg[TW-1:0];
    assign i_is_t  = (i_cur == t_reg);
    assign i_is_ru = (i_cur == sh_ru_reg);
    assign step_wr = phase_reg[0];
    assign epw_ok  = (sh_wt_reg <= cw_reg);
    assign epr_ok  = (sh_rt_reg <= cr_reg);

    // the walk reads src from port 2 and dst from port 1
    always_comb begin
        jmax = (tc2_rd > tc_rd) ? tc2_rd : tc_rd;
    end

    // memory addressing and write data
    always_comb begin
        tc_we = 1'b0; lc_we = 1'b0; rv_we = 1'b0; sh_we = 1'b0;
        tc_addr = '0; tc2_addr = '0; lc_addr = '0; rv_addr = '0;
        sh_addr = x_reg;
        tc_wd = '0; lc_wd = '0; rv_wd = '0; sh_wd = '0;
        unique case (cmd.cmd)
            CMD_CLR: begin
                if (clr_reg < CW'(TCD)) begin
                    tc_we = 1'b1; tc_addr = clr_reg[TCA-1:0];
                end
                if (clr_reg < CW'(LCD)) begin
                    lc_we = 1'b1; lc_addr = clr_reg[LCA-1:0];
                end
                if (clr_reg < CW'(NumVars)) begin
                    sh_we = 1'b1; sh_addr = clr_reg[VW-1:0];
                end
            end
            CMD_LOAD: begin
                sh_addr = VW'(s_variable);
            end
            CMD_CHK: begin
                // read c[t] and c[write thread] first, then c[read thread] and the peer's own entry
                unique case (phase_reg)
                    2'd0: begin
                        // write thread comes straight from the shadow read data
                        tc_addr  = tca(t_reg, t_reg);
                        tc2_addr = tca(t_reg, sh_rd[TW-1:0]);
                    end
                    default: begin
                        tc_addr  = tca(t_reg, sh_ru_reg);
                        tc2_addr = tca(u_reg, u_reg);
                    end
                endcase
            end
            CMD_WALK: begin
                if (!step_wr) begin
                    unique case (op_reg)
                        OP_ACQUIRE: begin
                            tc_addr = tca(t_reg, i_cur);
                            lc_addr = LCA'(m_reg) * LCA'(NumThreads) + LCA'(i_cur);
                        end
                        OP_RELEASE: tc_addr = tca(t_reg, i_cur);
                        OP_FORK: begin
                            tc_addr  = tca(u_reg, i_cur);
                            tc2_addr = tca(t_reg, i_cur);
                        end
                        OP_JOIN: begin
                            tc_addr  = tca(t_reg, i_cur);
                            tc2_addr = tca(u_reg, i_cur);
                        end
                        default: begin
                            tc_addr = tca(t_reg, i_cur);
                            rv_addr = RVA'(x_reg) * RVA'(NumThreads) + RVA'(i_cur);
                        end
                    endcase
                end else begin
                    unique case (op_reg)
                        OP_ACQUIRE: begin
                            tc_we = 1'b1; tc_addr = tca(t_reg, i_cur);
                            tc_wd = (lc_rd > tc_rd) ? lc_rd : tc_rd;
                        end
                        OP_RELEASE: begin
                            lc_we = 1'b1;
                            lc_addr = LCA'(m_reg) * LCA'(NumThreads) + LCA'(i_cur);
                            lc_wd = tc_rd;
                        end
                        OP_FORK: begin
                            tc_we = 1'b1; tc_addr = tca(u_reg, i_cur);
                            tc_wd = jmax;
                        end
                        OP_JOIN: begin
                            tc_we = 1'b1; tc_addr = tca(t_reg, i_cur);
                            tc_wd = jmax;
                        end
                        OP_READ: begin
                            rv_we = 1'b1;
                            rv_addr = RVA'(x_reg) * RVA'(NumThreads) + RVA'(i_cur);
                            rv_wd = i_is_t ? ct_reg : (i_is_ru ? sh_rt_reg : '0);
                        end
                        default: begin
                            rv_addr = RVA'(x_reg) * RVA'(NumThreads) + RVA'(i_cur);
                        end
                    endcase
                end
            end
            CMD_FINISH: begin
                if (valid_ev_reg && !race_reg) begin
                    unique case (op_reg)
                        OP_READ: begin
                            if (sh_vec_reg) begin
                                rv_we = 1'b1;
                                rv_addr = RVA'(x_reg) * RVA'(NumThreads) + RVA'(t_reg);
                                rv_wd = ct_reg;
                            end else if (!need_walk_reg && kind_reg == KIND_NONE
                                         && !(sh_rt_reg == ct_reg && sh_ru_reg == t_reg)) begin
                                sh_we = 1'b1;
                                sh_wd = {1'b0, ct_reg, t_reg, sh_wt_reg, sh_wu_reg};
                            end else if (need_walk_reg) begin
                                sh_we = 1'b1;
                                sh_wd = {1'b1, sh_rt_reg, sh_ru_reg, sh_wt_reg, sh_wu_reg};
                            end
                        end
                        OP_WRITE: begin
                            if (!(sh_wt_reg == ct_reg && sh_wu_reg == t_reg)) begin
                                sh_we = 1'b1;
                                sh_wd = sh_vec_reg
                                    ? {1'b0, {ClockBits{1'b0}}, {TW{1'b0}}, ct_reg, t_reg}
                                    : {1'b0, sh_rt_reg, sh_ru_reg, ct_reg, t_reg};
                            end
                        end
                        OP_RELEASE: begin
                            if (ct_reg != ClkMax) begin
                                tc_we = 1'b1; tc_addr = tca(t_reg, t_reg);
                                tc_wd = ct_reg + 1'b1;
                            end
                        end
                        OP_FORK: begin
                            if (ct_reg != ClkMax) begin
                                tc_we = 1'b1; tc_addr = tca(t_reg, t_reg);
                                tc_wd = ct_reg + 1'b1;
                            end
                        end
                        OP_JOIN: begin
                            if (cu_reg != ClkMax) begin
                                tc_we = 1'b1; tc_addr = tca(u_reg, u_reg);
                                tc_wd = cu_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // step the datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg       <= '0;
            phase_reg     <= '0;
            idx_reg       <= '0;
            race_reg      <= 1'b0;
            kind_reg      <= KIND_NONE;
            need_walk_reg <= 1'b0;
            valid_ev_reg  <= 1'b0;
        end else begin
            unique case (cmd.cmd)
                CMD_CLR: clr_reg <= clr_reg + 1'b1;
                CMD_LOAD: begin
                    op_reg  <= s_op;
                    t_reg   <= TW'(s_thread);
                    u_reg   <= TW'(s_peer_thread);
                    x_reg   <= VW'(s_variable);
                    m_reg   <= LW'(s_lock_id);
                    valid_ev_reg <= (32'(s_thread) < NumThreads) &&
                        (((s_op == OP_READ || s_op == OP_WRITE) && 32'(s_variable) < NumVars)
                      || ((s_op == OP_ACQUIRE || s_op == OP_RELEASE) && 32'(s_lock_id) < NumLocks)
                      || ((s_op == OP_FORK || s_op == OP_JOIN) && 32'(s_peer_thread) < NumThreads));
                    race_reg  <= 1'b0;
                    kind_reg  <= KIND_NONE;
                    need_walk_reg <= 1'b0;
                    phase_reg <= '0;
                    idx_reg   <= '0;
                end
                CMD_CHK: begin
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == 2'd0) begin
                        {sh_vec_reg, sh_rt_reg, sh_ru_reg, sh_wt_reg, sh_wu_reg} <= sh_rd;
                    end else if (phase_reg == 2'd1) begin
                        ct_reg <= tc_rd;
                        cw_reg <= tc2_rd;
                    end else if (phase_reg == 2'd2) begin
                        cr_reg <= tc_rd;
                        cu_reg <= tc2_rd;
                    end else begin
                        // decide race and whether a vector walk follows
                        phase_reg <= '0;
                        if (op_reg == OP_READ && valid_ev_reg) begin
                            if (!sh_vec_reg && sh_rt_reg == ct_reg && sh_ru_reg == t_reg) begin
                                need_walk_reg <= 1'b0;
                            end else if (!epw_ok) begin
                                race_reg <= 1'b1; kind_reg <= KIND_WR;
                            end else if (!sh_vec_reg && !epr_ok) begin
                                need_walk_reg <= 1'b1;
                            end
                        end else if (op_reg == OP_WRITE && valid_ev_reg) begin
                            if (sh_wt_reg == ct_reg && sh_wu_reg == t_reg) begin
                                need_walk_reg <= 1'b0;
                            end else if (!epw_ok) begin
                                race_reg <= 1'b1; kind_reg <= KIND_WW;
                            end else if (!sh_vec_reg) begin
                                if (!epr_ok) begin
                                    race_reg <= 1'b1; kind_reg <= KIND_RW;
                                end
                            end else begin
                                need_walk_reg <= 1'b1;
                            end
                        end else if (valid_ev_reg) begin
                            need_walk_reg <= 1'b1;
                        end
                    end
                end
                CMD_WALK: begin
                    phase_reg <= {1'b0, ~step_wr};
                    // write-after-vector-read check compares rv[i] to c[i]
                    if (step_wr && op_reg == OP_WRITE && rv_rd > tc_rd) begin
                        race_reg <= 1'b1; kind_reg <= KIND_RW;
                    end
                    if (step_wr) idx_reg <= idx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // a read that fell off the walk (out-of-range thread) is not possible
    assign sts.clr_done  = (clr_reg >= CW'(CLRN));
    assign sts.walk_done = step_wr && (idx_reg == (TW+1)'(NumThreads - 1));
    assign sts.need_walk = need_walk_reg && !race_reg;
    assign res_race      = race_reg;
    assign res_kind      = kind_reg;
endmodule : vcrd_datapath
`default_nettype wire

>>> rtl/vcrd_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcrd_ctrl: sequencer for the race detector
// Runs the clearing pass, then per request: load, check, walk if needed, finish, output.
// ---------------------------------------------------------------------------
module vcrd_ctrl import vcrd_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire vcrd_sts_t sts,
    output vcrd_cmd_t      cmd,
    output logic           cap
);
    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_CHK, ST_WALK, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   [1:0] chk_reg, chk_next;
    logic   m_valid_reg, m_valid_next;

    // next state
    always_comb begin
        state_next   = state_reg;
        chk_next     = chk_reg;
        m_valid_next = m_valid_reg;
        cmd.cmd      = CMD_NONE;
        cap          = 1'b0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.cmd = CMD_CLR;
                if (sts.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.cmd = CMD_LOAD; state_next = ST_CHK; chk_next = '0;
                end
            end
            ST_CHK: begin
                cmd.cmd = CMD_CHK; chk_next = chk_reg + 1'b1;
                if (chk_reg == 2'd3) state_next = ST_WALK;
            end
            ST_WALK: begin
                if (!sts.need_walk) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.cmd = CMD_WALK;
                    if (sts.walk_done) state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for a free output register
                if (!m_valid_reg || m_ready) begin
                    cmd.cmd = CMD_FINISH; cap = 1'b1;
                    m_valid_next = 1'b1; state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            chk_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chk_reg     <= chk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_no_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !s_ready)
        else $error("request accepted during clearing pass");
    a_out_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        cap |=> m_valid)
        else $error("finished request left no result");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");
`endif
endmodule : vcrd_ctrl
`default_nettype wire
